>>> sv/sha_pkg.sv
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       finish;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Round constants
  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // Initial hash values
  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

>>> sv/sha_if.sv
interface sha_in_if;
  import sha_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
  import sha_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/sha_round.sv
// One compression round plus one message schedule step over a sliding
// sixteen-word window. Purely combinational; the sequencer holds the state.
module sha_round (
  input  sha_pkg::word_t [7:0]  st_i,
  input  sha_pkg::word_t [15:0] w_i,
  input  logic [5:0]            rnd_i,
  output sha_pkg::word_t [7:0]  st_o,
  output sha_pkg::word_t [15:0] w_o
);
  import sha_pkg::*;

  word_t t1, t2, s0, s1, wn;

  // Round function on a..h
  always_comb begin
    t1 = st_i[7] + (rotr(st_i[4], 6) ^ rotr(st_i[4], 11) ^ rotr(st_i[4], 25))
       + ((st_i[4] & st_i[5]) ^ (~st_i[4] & st_i[6])) + round_k(rnd_i) + w_i[0];
    t2 = (rotr(st_i[0], 2) ^ rotr(st_i[0], 13) ^ rotr(st_i[0], 22))
       + ((st_i[0] & st_i[1]) ^ (st_i[0] & st_i[2]) ^ (st_i[1] & st_i[2]));
    st_o[7] = st_i[6];
    st_o[6] = st_i[5];
    st_o[5] = st_i[4];
    st_o[4] = st_i[3] + t1;
    st_o[3] = st_i[2];
    st_o[2] = st_i[1];
    st_o[1] = st_i[0];
    st_o[0] = t1 + t2;
  end

  // Schedule: next word enters at the top of the window
  always_comb begin
    s0 = rotr(w_i[1], 7) ^ rotr(w_i[1], 18) ^ (w_i[1] >> 3);
    s1 = rotr(w_i[14], 17) ^ rotr(w_i[14], 19) ^ (w_i[14] >> 10);
    wn = s1 + w_i[9] + s0 + w_i[0];
    for (int i = 0; i < 15; i++) w_o[i] = w_i[i+1];
    w_o[15] = wn;
  end

endmodule

>>> sv/sha256_stream_hasher.sv
// Channel | Dir | Payload                                 | Transaction when
// in_if   | in  | data_byte[7:0], byte_valid, finish      | valid && ready
// out_if  | out | digest_word[31:0], word_index[2:0], last| valid && ready
//
// A byte that does not complete a block is taken in StIdle alone; one that completes
// a block also runs the 64 rounds (StRound) and the hash update (StAdd) through the
// shared round unit. Finish adds one or two padded blocks and 8 output words.
// Block bytes live in the 16-word schedule window, shifted in as they arrive.
// Reset is asynchronous; it loads the initial hash values and clears counts.
// The output stalls only the digest phase; input is not ready meanwhile.
module sha256_stream_hasher (
  input  logic clk_i,
  input  logic rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRound = 5'b00010,
    StAdd   = 5'b00100,
    StPad   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  word_t [7:0]         h_q, h_d, st_q, st_d, st_nx;
  word_t [15:0]        w_q, w_d, w_nx;
  logic [5:0]          fill_q, fill_d, rnd_q, rnd_d;
  logic [63:0]         bits_q, bits_d;
  logic                fin_q, fin_d;     // finish pending
  logic                pad2_q, pad2_d;   // second padded block still due
  logic                lenin_q, lenin_d; // current block is the final one
  logic [2:0]          oidx_q, oidx_d;
  logic [7:0]          byte_sel;
  word_t [15:0]        w_shift;
  word_t [15:0]        pad_blk;

  sha_round u_round (.st_i(st_q), .w_i(w_q), .rnd_i(rnd_q), .st_o(st_nx), .w_o(w_nx));

  assign in_if.ready    = (state_q == StIdle);
  assign out_if.valid   = (state_q == StOut);
  assign out_if.payload = '{digest_word: h_q[oidx_q], word_index: oidx_q,
                            last_word: (oidx_q == 3'd7)};
  assign byte_sel       = in_if.payload.data_byte;

  // Window with the new byte shifted in at the bottom
  assign w_shift        = 512'({w_q, byte_sel});

  // Padded block built from the window: window holds fill bytes shifted in
  always_comb begin
    logic [511:0] flat;
    logic [511:0] mask;
    logic [9:0]   sh;
    flat = w_q;
    sh   = {1'b0, fill_q, 3'b000};
    // bytes in the window are right-aligned; align them to the top
    flat = (fill_q == 6'd0) ? '0 : (flat << (10'd512 - sh));
    mask = {8'h80, 504'd0} >> sh;
    flat = pad2_q ? '0 : (flat | mask);
    if (!(pad2_q == 1'b0 && fill_q > 6'd55)) flat[63:0] = bits_q;
    for (int i = 0; i < 16; i++) pad_blk[i] = flat[511 - 32*i -: 32];
  end

  // Sequencer
  always_comb begin
    state_d = state_q; h_d = h_q; st_d = st_q; w_d = w_q; fill_d = fill_q;
    rnd_d = rnd_q; bits_d = bits_q; fin_d = fin_q; pad2_d = pad2_q;
    lenin_d = lenin_q; oidx_d = oidx_q;
    case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          fin_d = in_if.payload.finish;
          if (in_if.payload.byte_valid) begin
            bits_d = bits_q + 64'd8;
            fill_d = fill_q + 6'd1;
            w_d    = w_shift;
            if (fill_q == 6'd63) begin
              // full block: reorder the 16 words to round order
              for (int i = 0; i < 16; i++) w_d[i] = w_shift[15 - i];
              st_d = h_q; rnd_d = '0; lenin_d = 1'b0; state_d = StRound;
            end else if (in_if.payload.finish) state_d = StPad;
          end else if (in_if.payload.finish) state_d = StPad;
        end
      end
      StPad: begin
        w_d = pad_blk; st_d = h_q; rnd_d = '0;
        lenin_d = pad2_q || !(fill_q > 6'd55);
        pad2_d  = !pad2_q && (fill_q > 6'd55);
        fin_d   = 1'b1; state_d = StRound;
      end
      StRound: begin
        st_d = st_nx; w_d = w_nx; rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) state_d = StAdd;
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + st_q[i];
        if (!lenin_q && !pad2_q) fill_d = '0;
        if (lenin_q) begin
          oidx_d = '0; state_d = StOut;
        end else if (pad2_q || fin_q) state_d = StPad;
        else state_d = StIdle;
      end
      StOut: begin
        if (out_if.ready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_d[i] = init_h(3'(i));
            fill_d = '0; bits_d = '0; fin_d = 1'b0; pad2_d = 1'b0;
            lenin_d = 1'b0; state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
      fill_q <= '0; bits_q <= '0; fin_q <= 1'b0; pad2_q <= 1'b0;
      lenin_q <= 1'b0; oidx_q <= '0; rnd_q <= '0;
    end else begin
      state_q <= state_d; h_q <= h_d; fill_q <= fill_d; bits_q <= bits_d;
      fin_q <= fin_d; pad2_q <= pad2_d; lenin_q <= lenin_d; oidx_q <= oidx_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    w_q  <= w_d;
  end

endmodule

>>> sv/sha_checker.sv
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  word_index_i,
  input logic        last_word_i,
  input logic [31:0] digest_word_i
);
  // never accept input while a digest is on offer
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("input ready during digest");
  // last flag marks word seven
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_word_i == (word_index_i == 3'd7))) else $error("last flag");
  // words advance by one per transaction
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_word_i) |=> (out_valid_i &&
      word_index_i == $past(word_index_i) + 3'd1)) else $error("word order");
  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(digest_word_i)) else $error("stall");
endmodule

bind sha256_stream_hasher sha_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .word_index_i(out_if.payload.word_index), .last_word_i(out_if.payload.last_word),
  .digest_word_i(out_if.payload.digest_word)
);

>>> tb/sv/sha256_digest_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts SHA-256 digests and checks them
module sha256_digest_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  sha_in_if.sink in_mon,
  sha_out_if.sink out_mon,
  output int     fail_count_o,
  output int     digests_o,
  output int     pending_o
);
  import sha_pkg::*;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0] hash_q [8];
  logic [7:0]  blk_q [64];
  int unsigned fill_q;
  logic [63:0] bit_len_q;
  out_item_t   digest_q [$];
  int          fails;
  int          digests;
  int          pending;

  function automatic logic [31:0] ror32(logic [31:0] v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // One 64-round compression of a block into hash_q
  task automatic compress_block(input logic [7:0] b [64]);
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    r = hash_q;
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
           + ((r[4] & r[5]) ^ (~r[4] & r[6])) + K_TAB[i] + w[i];
      t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
           + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += r[i];
  endtask

  task automatic restart_message();
    hash_q = IV_TAB;
    fill_q = 0;
    bit_len_q = '0;
  endtask

  // Absorb one accepted item; on finish pad and queue eight digest words
  task automatic absorb_item(input in_item_t it);
    logic [7:0] pad [64];
    out_item_t  o;
    if (it.byte_valid) begin
      blk_q[fill_q] = it.data_byte;
      fill_q++;
      bit_len_q += 64'd8;
      if (fill_q == 64) begin
        compress_block(blk_q);
        fill_q = 0;
      end
    end
    if (it.finish) begin
      for (int i = 0; i < 64; i++) pad[i] = (i < fill_q) ? blk_q[i] : 8'h00;
      pad[fill_q] = 8'h80;
      if (fill_q + 1 > 56) begin
        compress_block(pad);
        for (int i = 0; i < 64; i++) pad[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) pad[63-i] = bit_len_q[8*i +: 8];
      compress_block(pad);
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_q[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        digest_q.push_back(o);
      end
      restart_message();
    end
  endtask

  // Input side first, then the output side, on each edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_w;
    if (!rst_ni) begin
      restart_message();
      digest_q.delete();
      fails = 0;
      digests = 0;
      pending = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) absorb_item(in_mon.payload);
      if (out_mon.valid && out_mon.ready) begin
        if (digest_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected digest word %h idx %0d",
            out_mon.payload.digest_word, out_mon.payload.word_index);
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w.last_word) digests++;
          if (out_mon.payload !== exp_w) begin
            fails++;
            if (fails <= 10)
              $display("mismatch exp %h/%0d/%0b got %h/%0d/%0b",
                exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                out_mon.payload.digest_word, out_mon.payload.word_index,
                out_mon.payload.last_word);
          end
        end
      end
      pending = digest_q.size();
    end
  end

  assign fail_count_o = fails;
  assign digests_o    = digests;
  assign pending_o    = pending;
endmodule

>>> tb/sv/tb_sha256_stream_hasher.sv
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;
  import sha_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, digests_seen, words_pending;
  int   idle_cycles = 0;
  int   sent = 0;
  bit   long_stall = 1'b0;
  bit   stall_done = 1'b0;

  sha_in_if  msg_if ();
  sha_out_if dig_if ();

  sha256_stream_hasher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (msg_if.sink),
    .out_if (dig_if.source)
  );

  sha256_digest_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (msg_if.sink),
    .out_mon      (dig_if.sink),
    .fail_count_o (fail_count),
    .digests_o    (digests_seen),
    .pending_o    (words_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    msg_if.valid = 1'b0;
    msg_if.payload = '0;
    dig_if.ready = 1'b0;
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: own stall pattern plus one long hold-off
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        dig_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_stall = 1'b0;
        stall_done = 1'b1;
      end
      mode = (sent / 60) % 3;
      if (mode == 0) dig_if.ready <= 1'b1;
      else if (mode == 1) dig_if.ready <= ($urandom_range(0, 3) != 0);
      else dig_if.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Hold one transaction until accepted
  task automatic send_item(input logic [7:0] b, input bit bv, input bit fin);
    msg_if.valid <= 1'b1;
    msg_if.payload <= '{data_byte: b, byte_valid: bv, finish: fin};
    do @(posedge clk_i); while (!msg_if.ready);
    sent++;
  endtask

  task automatic send_gap();
    msg_if.valid <= 1'b0;
    msg_if.payload <= '{data_byte: 8'($urandom), byte_valid: 1'b1, finish: 1'b1};
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // Message of given length, bursty source
  task automatic send_message(input int len, input bit noise);
    int burst;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1));
      if (--burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) send_gap();
      end
    end
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, extremes, idle item, bit-only finish
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_message(55, 1'b0);
    // Long receiver hold-off while a message streams in
    long_stall = 1'b1;
    send_message(56, 1'b0);
    send_message(3, 1'b0);
    wait (stall_done);
    // Random: mostly short messages, boundary lengths now and then
    while (sent < 330) begin
      case ($urandom_range(0, 5))
        0: len = 63 + $urandom_range(0, 2);
        1: len = 0;
        default: len = $urandom_range(1, 12);
      endcase
      send_message(len, 1'b1);
    end
    msg_if.valid <= 1'b0;
    wait (words_pending == 0);
    repeat (200) @(posedge clk_i);
    $display("sent %0d items, checked %0d digests incl. empty and block-boundary messages",
             sent, digests_seen);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
